FILE: hw/rtl/rts_frame_waveform_transmitter_core_defines.svh
// Assertion macros for the frame waveform transmitter core
`ifndef RTS_FRAME_WAVEFORM_TRANSMITTER_CORE_DEFINES_SVH
`define RTS_FRAME_WAVEFORM_TRANSMITTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define RTSFW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rtsfw: assertion failed");

// next-cycle implication, disabled while reset is active
`define RTSFW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rtsfw: assertion failed");

`endif

FILE: hw/rtl/rtsfw_pkg.sv
// Shared types and constants for the frame waveform transmitter
`default_nettype none
package rtsfw_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int FRAME_BITS  = 56;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_REMOTE_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_US      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WAKEUP_HIGH_US = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAKEUP_LOW_US  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SOFT_SYNC_HIGH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_LOW_US     = 3'd6;

    typedef struct packed {
        logic [23:0] remote_address;
        logic [7:0]  key_byte;
        logic [11:0] symbol_us;
        logic [15:0] wakeup_high_us;
        logic [16:0] wakeup_low_us;
        logic [15:0] soft_sync_high_us;
        logic [16:0] gap_low_us;
    } cfg_t;

    typedef struct packed {
        logic                  cmd;
        logic [FRAME_BITS-1:0] frame;
        logic [7:0]            repeats;
    } q_entry_t;

    typedef struct packed {
        logic pop;
        logic pop_idle_tick;
    } bk_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rtsfw_front.sv
// Input side: accept items and build the obfuscated frame
`default_nettype none
module rtsfw_front
    import rtsfw_pkg::*;
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire cfg_t                 cfg,
    input  wire logic                 q_full,
    output logic                      q_push,
    output q_entry_t                  q_wr_entry
);

    function automatic logic [FRAME_BITS-1:0] build_frame(
        input logic [7:0]  key,
        input logic [3:0]  button,
        input logic [15:0] code,
        input logic [23:0] addr
    );
        logic [7:0] b [7];
        logic [3:0] cks;
        logic [FRAME_BITS-1:0] f;
        b[0] = key;
        b[1] = {button, 4'b0000};
        b[2] = code[15:8];
        b[3] = code[7:0];
        b[4] = addr[23:16];
        b[5] = addr[15:8];
        b[6] = addr[7:0];
        cks = 4'b0000;
        for (int i = 0; i < 7; i++) begin
            cks = cks ^ b[i][3:0] ^ b[i][7:4];
        end
        b[1][3:0] = cks;
        for (int i = 1; i < 7; i++) begin
            b[i] = b[i] ^ b[i-1];
        end
        f = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
        return f;
    endfunction

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_wr_entry.cmd     = s_tuser;
        q_wr_entry.repeats = s_tdata[27:20];
        q_wr_entry.frame   = build_frame(cfg.key_byte, s_tdata[3:0], s_tdata[19:4],
                                         cfg.remote_address);
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rtsfw_queue.sv
// Short item queue between the front and the back
`default_nettype none
module rtsfw_queue
    import rtsfw_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t wr_entry,
    output logic          full,
    input  wire logic     pop,
    output logic          rd_valid,
    output q_entry_t      rd_entry
);

    q_entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg;

    assign full     = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rtsfw_back.sv
// Segment sequencer: runs the waveform, one queued item per cycle while the output is not stalled
`default_nettype none
module rtsfw_back
    import rtsfw_pkg::*;
#(
    parameter int DW = 17
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire logic                  q_valid,
    input  wire q_entry_t              q_entry,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output bk_status_t                 status
);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_WAKE_H = 4'd1;
    localparam logic [3:0] PH_WAKE_L = 4'd2;
    localparam logic [3:0] PH_HW_H   = 4'd3;
    localparam logic [3:0] PH_HW_L   = 4'd4;
    localparam logic [3:0] PH_SOFT_H = 4'd5;
    localparam logic [3:0] PH_SOFT_L = 4'd6;
    localparam logic [3:0] PH_DATA   = 4'd7;
    localparam logic [3:0] PH_GAP    = 4'd8;

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [3:0]            phase_reg, phase_next;
    logic [DW-1:0]         time_reg, time_next;
    logic [5:0]            bit_reg, bit_next;
    logic                  half_reg, half_next;
    logic [2:0]            sync_reg, sync_next;
    logic [7:0]            repeats_reg, repeats_next;
    logic                  level_reg, level_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [11:0]   sym;
    logic [DW-1:0] sym_d;
    logic [DW-1:0] sync_d;
    logic          lvl;
    logic          res_level;
    logic          res_busy;
    logic          res_done;

    assign sym    = (cfg.symbol_us == '0) ? 12'd1 : cfg.symbol_us;
    assign sym_d  = DW'(sym);
    assign sync_d = DW'({sym, 2'b00});

    assign q_pop    = q_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.pop           = q_pop;
    assign status.pop_idle_tick = q_pop && !q_entry.cmd && (phase_reg == PH_IDLE);

    always_comb begin
        if (phase_reg inside {PH_WAKE_H, PH_HW_H, PH_SOFT_H}) begin
            lvl = 1'b1;
        end else if (phase_reg == PH_DATA) begin
            lvl = half_reg ? frame_reg[FRAME_BITS-1] : !frame_reg[FRAME_BITS-1];
        end else begin
            lvl = 1'b0;
        end
    end

    always_comb begin
        frame_next   = frame_reg;
        phase_next   = phase_reg;
        time_next    = time_reg;
        bit_next     = bit_reg;
        half_next    = half_reg;
        sync_next    = sync_reg;
        repeats_next = repeats_reg;
        level_next   = level_reg;
        res_level    = level_reg;
        res_busy     = 1'b1;
        res_done     = 1'b0;

        if (q_pop) begin
            if (q_entry.cmd) begin
                if (phase_reg == PH_IDLE) begin
                    frame_next   = q_entry.frame;
                    repeats_next = q_entry.repeats;
                    sync_next    = 3'd2;
                    bit_next     = '0;
                    half_next    = 1'b0;
                    if (cfg.wakeup_high_us != '0) begin
                        phase_next = PH_WAKE_H;
                        time_next  = DW'(cfg.wakeup_high_us);
                    end else if (cfg.wakeup_low_us != '0) begin
                        phase_next = PH_WAKE_L;
                        time_next  = DW'(cfg.wakeup_low_us);
                    end else begin
                        phase_next = PH_HW_H;
                        time_next  = sync_d;
                    end
                end
            end else if (phase_reg == PH_IDLE) begin
                level_next = 1'b0;
                res_level  = 1'b0;
                res_busy   = 1'b0;
            end else begin
                level_next = lvl;
                time_next  = time_reg - 1'b1;
                if (time_reg == DW'(1)) begin
                    case (phase_reg)
                        PH_WAKE_H: begin
                            if (cfg.wakeup_low_us != '0) begin
                                phase_next = PH_WAKE_L;
                                time_next  = DW'(cfg.wakeup_low_us);
                            end else begin
                                phase_next = PH_HW_H;
                                time_next  = sync_d;
                            end
                        end
                        PH_WAKE_L: begin
                            phase_next = PH_HW_H;
                            time_next  = sync_d;
                        end
                        PH_HW_H: begin
                            phase_next = PH_HW_L;
                            time_next  = sync_d;
                        end
                        PH_HW_L: begin
                            if (sync_reg > 3'd1) begin
                                sync_next  = sync_reg - 1'b1;
                                phase_next = PH_HW_H;
                                time_next  = sync_d;
                            end else begin
                                sync_next = '0;
                                if (cfg.soft_sync_high_us != '0) begin
                                    phase_next = PH_SOFT_H;
                                    time_next  = DW'(cfg.soft_sync_high_us);
                                end else begin
                                    phase_next = PH_SOFT_L;
                                    time_next  = sym_d;
                                end
                            end
                        end
                        PH_SOFT_H: begin
                            phase_next = PH_SOFT_L;
                            time_next  = sym_d;
                        end
                        PH_SOFT_L: begin
                            bit_next   = '0;
                            half_next  = 1'b0;
                            phase_next = PH_DATA;
                            time_next  = sym_d;
                        end
                        PH_DATA: begin
                            if (!half_reg) begin
                                half_next = 1'b1;
                                time_next = sym_d;
                            end else begin
                                half_next  = 1'b0;
                                frame_next = {frame_reg[FRAME_BITS-2:0],
                                              frame_reg[FRAME_BITS-1]};
                                if (bit_reg == 6'(FRAME_BITS-1)) begin
                                    bit_next = '0;
                                    if (cfg.gap_low_us != '0) begin
                                        phase_next = PH_GAP;
                                        time_next  = DW'(cfg.gap_low_us);
                                    end else if (repeats_reg != '0) begin
                                        repeats_next = repeats_reg - 1'b1;
                                        sync_next    = 3'd7;
                                        phase_next   = PH_HW_H;
                                        time_next    = sync_d;
                                    end else begin
                                        phase_next = PH_IDLE;
                                        time_next  = '0;
                                        res_done   = 1'b1;
                                    end
                                end else begin
                                    bit_next  = bit_reg + 1'b1;
                                    time_next = sym_d;
                                end
                            end
                        end
                        PH_GAP: begin
                            if (repeats_reg != '0) begin
                                repeats_next = repeats_reg - 1'b1;
                                sync_next    = 3'd7;
                                phase_next   = PH_HW_H;
                                time_next    = sync_d;
                            end else begin
                                phase_next = PH_IDLE;
                                time_next  = '0;
                                res_done   = 1'b1;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            time_next  = '0;
                            res_done   = 1'b1;
                        end
                    endcase
                end
                res_level = lvl;
                res_busy  = (phase_next != PH_IDLE);
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (q_pop) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W-3){1'b0}}, res_done, res_busy, res_level};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg   <= frame_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            time_reg     <= '0;
            bit_reg      <= '0;
            half_reg     <= 1'b0;
            sync_reg     <= '0;
            repeats_reg  <= '0;
            level_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            time_reg     <= time_next;
            bit_reg      <= bit_next;
            half_reg     <= half_next;
            sync_reg     <= sync_next;
            repeats_reg  <= repeats_next;
            level_reg    <= level_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rts_frame_waveform_transmitter_core.sv
// Top level of the rolling-code frame waveform transmitter
//
//  port group   dir  payload (low bit first)
//  s_*          in   tuser: cmd; tdata: button, rolling_code, repeat_count
//  m_*          out  tdata: pin_level, busy_res, done_res
//  cfg_*        in   register write: index, data
//
// One item per cycle sustained while the output is not stalled; each item yields one result item.
// An accepted item is written into the four-entry queue; the edge that pops it
// also loads the output register; the sequencer retires one item per cycle unless the output stalls.
// Reset is synchronous and active low; no clearing pass is needed.
// An output stall fills the queue, then s_tready drops.
`default_nettype none
`include "rts_frame_waveform_transmitter_core_defines.svh"
module rts_frame_waveform_transmitter_core
    import rtsfw_pkg::*;
#(
    parameter int DURATION_WIDTH = 17
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // button, rolling_code, repeat_count
    input  wire logic                   s_tuser,   // cmd
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // pin_level, busy_res, done_res
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t       cfg_reg;
    logic       q_full;
    logic       q_push;
    q_entry_t   q_wr_entry;
    logic       q_pop;
    logic       q_valid;
    q_entry_t   q_rd_entry;
    bk_status_t bk_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.remote_address    <= 24'd0;
            cfg_reg.key_byte          <= 8'hA7;
            cfg_reg.symbol_us         <= 12'd640;
            cfg_reg.wakeup_high_us    <= 16'd9415;
            cfg_reg.wakeup_low_us     <= 17'd89565;
            cfg_reg.soft_sync_high_us <= 16'd4550;
            cfg_reg.gap_low_us        <= 17'd30415;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REMOTE_ADDRESS: cfg_reg.remote_address    <= cfg_wdata;
                REG_KEY_BYTE:       cfg_reg.key_byte          <= cfg_wdata[7:0];
                REG_SYMBOL_US:      cfg_reg.symbol_us         <= cfg_wdata[11:0];
                REG_WAKEUP_HIGH_US: cfg_reg.wakeup_high_us    <= cfg_wdata[15:0];
                REG_WAKEUP_LOW_US:  cfg_reg.wakeup_low_us     <= cfg_wdata[16:0];
                REG_SOFT_SYNC_HIGH: cfg_reg.soft_sync_high_us <= cfg_wdata[15:0];
                REG_GAP_LOW_US:     cfg_reg.gap_low_us        <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    rtsfw_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wr_entry (q_wr_entry)
    );

    rtsfw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_entry (q_rd_entry)
    );

    rtsfw_back #(
        .DW (DURATION_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_entry  (q_rd_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (bk_status)
    );

    `RTSFW_ASSERT_NOW(a_done_clears_busy, m_tvalid && m_tdata[2], !m_tdata[1])
    `RTSFW_ASSERT_NEXT(a_pop_gives_item, bk_status.pop, m_tvalid)
    `RTSFW_ASSERT_NEXT(a_idle_tick_low, bk_status.pop_idle_tick, m_tdata[2:0] == 3'b000)

endmodule
`default_nettype wire

FILE: tb/sv/rts_frame_waveform_transmitter_core_tb.sv
// Self-checking testbench for the rolling-code frame waveform transmitter core
`timescale 1ns / 1ps
module rts_frame_waveform_transmitter_core_tb;
    import rtsfw_pkg::*;

    localparam int STUCK_LIMIT    = 1000;
    localparam int FIFO_AHEAD     = 4;
    localparam int RANDOM_ITEMS   = 500;
    localparam logic [12:0] READY_PATTERN = 13'b1110001101101;

    typedef enum logic [3:0] {
        SEG_IDLE, SEG_WAKE_HIGH, SEG_WAKE_LOW, SEG_SYNC_HIGH, SEG_SYNC_LOW,
        SEG_SOFT_HIGH, SEG_SOFT_LOW, SEG_DATA, SEG_GAP
    } seg_e;

    typedef struct packed {
        logic        start;
        logic [3:0]  btn;
        logic [15:0] code;
        logic [7:0]  reps;
    } stim_item_t;

    typedef struct packed {
        logic level;
        logic busy;
        logic done;
    } pin_sample_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;    // button, rolling_code, repeat_count
    logic                   s_tuser = 1'b0;  // cmd
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // pin_level, busy_res, done_res
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    rts_frame_waveform_transmitter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // register copies
    logic [23:0] r_addr;
    logic [7:0]  r_key;
    logic [11:0] r_sym;
    logic [15:0] r_wake_hi;
    logic [16:0] r_wake_lo;
    logic [15:0] r_soft_hi;
    logic [16:0] r_gap;

    // waveform sequencer state
    logic [55:0] tx_frame;
    seg_e        seg;
    logic [16:0] seg_left;
    logic [5:0]  bit_pos;
    logic        late_half;
    logic [2:0]  pairs_left;
    logic [7:0]  repeats_left;
    logic        pin;

    stim_item_t  pending[$];
    pin_sample_t level_expect_q[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  tx_started = 0;
    int  starts_dropped = 0;
    int  done_seen = 0;
    int  items_queued = 0;
    int  setups_loaded = 0;
    int  stuck = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_pos = 0;
    bit  steady = 1'b0;

    function automatic logic [11:0] half_bit_us();
        return (r_sym == 12'd0) ? 12'd1 : r_sym;
    endfunction

    function automatic void enter_seg(seg_e s);
        logic [16:0] d;
        seg = s;
        case (s)
            SEG_WAKE_HIGH: d = {1'b0, r_wake_hi};
            SEG_WAKE_LOW: d = r_wake_lo;
            SEG_SYNC_HIGH, SEG_SYNC_LOW: d = {3'b000, half_bit_us(), 2'b00};
            SEG_SOFT_HIGH: d = {1'b0, r_soft_hi};
            SEG_SOFT_LOW, SEG_DATA: d = {5'b00000, half_bit_us()};
            SEG_GAP: d = r_gap;
            default: d = '0;
        endcase
        seg_left = d;
    endfunction

    function automatic logic seg_level();
        case (seg)
            SEG_WAKE_HIGH, SEG_SYNC_HIGH, SEG_SOFT_HIGH: return 1'b1;
            SEG_DATA: return late_half ? tx_frame[6'd55 - bit_pos] : ~tx_frame[6'd55 - bit_pos];
            default: return 1'b0;
        endcase
    endfunction

    // step past a finished segment; 0 once the sequence is over
    function automatic logic advance_seg();
        case (seg)
            SEG_WAKE_HIGH: enter_seg(SEG_WAKE_LOW);
            SEG_WAKE_LOW: enter_seg(SEG_SYNC_HIGH);
            SEG_SYNC_HIGH: enter_seg(SEG_SYNC_LOW);
            SEG_SYNC_LOW: begin
                if (pairs_left > 3'd1) begin
                    pairs_left = pairs_left - 1'b1;
                    enter_seg(SEG_SYNC_HIGH);
                end else begin
                    pairs_left = 3'd0;
                    enter_seg(SEG_SOFT_HIGH);
                end
            end
            SEG_SOFT_HIGH: enter_seg(SEG_SOFT_LOW);
            SEG_SOFT_LOW: begin
                bit_pos = 6'd0;
                late_half = 1'b0;
                enter_seg(SEG_DATA);
            end
            SEG_DATA: begin
                if (!late_half) begin
                    late_half = 1'b1;
                    enter_seg(SEG_DATA);
                end else begin
                    late_half = 1'b0;
                    bit_pos = bit_pos + 1'b1;
                    if (bit_pos >= 6'd56) begin
                        bit_pos = 6'd0;
                        enter_seg(SEG_GAP);
                    end else begin
                        enter_seg(SEG_DATA);
                    end
                end
            end
            SEG_GAP: begin
                if (repeats_left > 8'd0) begin
                    repeats_left = repeats_left - 1'b1;
                    pairs_left = 3'd7;
                    enter_seg(SEG_SYNC_HIGH);
                end else begin
                    seg = SEG_IDLE;
                    seg_left = '0;
                    return 1'b0;
                end
            end
            default: begin
                seg = SEG_IDLE;
                seg_left = '0;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // skip zero-length segments
    function automatic logic settle_seg();
        while (seg_left == '0) begin
            if (!advance_seg())
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [55:0] obfuscated_frame(logic [3:0] btn, logic [15:0] code);
        logic [7:0] b [0:6];
        logic [3:0] cks;
        b[0] = r_key;
        b[1] = {btn, 4'h0};
        b[2] = code[15:8];
        b[3] = code[7:0];
        b[4] = r_addr[23:16];
        b[5] = r_addr[15:8];
        b[6] = r_addr[7:0];
        cks = 4'h0;
        for (int i = 0; i < 7; i++)
            cks = cks ^ b[i][3:0] ^ b[i][7:4];
        b[1][3:0] = cks;
        for (int i = 1; i < 7; i++)
            b[i] = b[i] ^ b[i-1];
        return {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
    endfunction

    function automatic void clear_model();
        r_addr = 24'd0;
        r_key = 8'hA7;
        r_sym = 12'd640;
        r_wake_hi = 16'd9415;
        r_wake_lo = 17'd89565;
        r_soft_hi = 16'd4550;
        r_gap = 17'd30415;
        tx_frame = '0;
        seg = SEG_IDLE;
        seg_left = '0;
        bit_pos = '0;
        late_half = 1'b0;
        pairs_left = '0;
        repeats_left = '0;
        pin = 1'b0;
    endfunction

    function automatic pin_sample_t predict_pin(stim_item_t it);
        pin_sample_t r;
        logic ended;
        ended = 1'b0;
        if (it.start) begin
            if (seg == SEG_IDLE) begin
                tx_frame = obfuscated_frame(it.btn, it.code);
                repeats_left = it.reps;
                pairs_left = 3'd2;
                bit_pos = 6'd0;
                late_half = 1'b0;
                enter_seg(SEG_WAKE_HIGH);
                void'(settle_seg());
                tx_started++;
            end else begin
                starts_dropped++;
            end
        end else if (seg == SEG_IDLE) begin
            pin = 1'b0;
        end else if (settle_seg()) begin
            pin = seg_level();
            seg_left = seg_left - 1'b1;
            if (seg_left == '0) begin
                if (!settle_seg())
                    ended = 1'b1;
            end
        end else begin
            ended = 1'b1;
        end
        r.level = pin;
        r.busy = (seg != SEG_IDLE);
        r.done = ended;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        stim_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_model();
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                level_expect_q.push_back(predict_pin({s_tuser, s_tdata[3:0], s_tdata[19:4],
                                                      s_tdata[27:20]}));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 && !steady) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    nxt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.start;
                    s_tdata <= {4'h0, nxt.reps, nxt.code, nxt.btn};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: fixed stall pattern, compare each result with the oldest expectation
    always @(posedge aclk) begin
        pin_sample_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_pos <= 0;
        end else begin
            stall_pos <= (stall_pos == 12) ? 0 : stall_pos + 1;
            m_tready <= steady || READY_PATTERN[stall_pos];
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (level_expect_q.size() == 0) begin
                    flag_mismatch("result with nothing expected, tdata", m_tdata, 0);
                end else begin
                    want = level_expect_q.pop_front();
                    if (want.done)
                        done_seen++;
                    if (m_tdata[0] !== want.level)
                        flag_mismatch("pin_level", m_tdata[0], want.level);
                    if (m_tdata[1] !== want.busy)
                        flag_mismatch("busy_res", m_tdata[1], want.busy);
                    if (m_tdata[2] !== want.done)
                        flag_mismatch("done_res", m_tdata[2], want.done);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
    end

    initial begin
        wait (stuck >= STUCK_LIMIT);
        $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic push_item(input logic start, input logic [3:0] btn,
                             input logic [15:0] code, input logic [7:0] reps);
        stim_item_t it;
        it.start = start;
        it.btn = btn;
        it.code = code;
        it.reps = reps;
        pending.push_back(it);
        items_queued++;
    endtask

    task automatic push_tick();
        push_item(1'b0, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
    endtask

    // start a transmission and feed ticks until it is over; noise = percent of stray starts
    task automatic run_sequence(input logic [3:0] btn, input logic [15:0] code,
                                input logic [7:0] reps, input int noise);
        push_item(1'b1, btn, code, reps);
        while (pending.size() != 0 || s_tvalid || seg != SEG_IDLE) begin
            if (pending.size() < FIFO_AHEAD && seg != SEG_IDLE) begin
                if ($urandom_range(0, 99) < noise)
                    push_item(1'b1, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 1)));
                else
                    push_tick();
            end else begin
                @(negedge aclk);
            end
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || s_tvalid || level_expect_q.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_REMOTE_ADDRESS: r_addr = val[23:0];
            REG_KEY_BYTE: r_key = val[7:0];
            REG_SYMBOL_US: r_sym = val[11:0];
            REG_WAKEUP_HIGH_US: r_wake_hi = val[15:0];
            REG_WAKEUP_LOW_US: r_wake_lo = val[16:0];
            REG_SOFT_SYNC_HIGH: r_soft_hi = val[15:0];
            REG_GAP_LOW_US: r_gap = val[16:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [23:0] addr, input logic [7:0] key,
                              input logic [11:0] sym, input logic [15:0] wake_hi,
                              input logic [16:0] wake_lo, input logic [15:0] soft_hi,
                              input logic [16:0] gap);
        drain();
        write_reg(REG_REMOTE_ADDRESS, addr);
        write_reg(REG_KEY_BYTE, CFG_DATA_W'(key));
        write_reg(REG_SYMBOL_US, CFG_DATA_W'(sym));
        write_reg(REG_WAKEUP_HIGH_US, CFG_DATA_W'(wake_hi));
        write_reg(REG_WAKEUP_LOW_US, CFG_DATA_W'(wake_lo));
        write_reg(REG_SOFT_SYNC_HIGH, CFG_DATA_W'(soft_hi));
        write_reg(REG_GAP_LOW_US, CFG_DATA_W'(gap));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        setups_loaded++;
    endtask

    initial begin
        int rand_base;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // idle ticks straight out of reset
        repeat (3) push_tick();

        // zero-length segments, zero symbol time
        load_setup(24'h000000, 8'h00, 12'd0, 16'd0, 17'd0, 16'd0, 17'd0);
        run_sequence(4'h0, 16'h0000, 8'd0, 0);
        run_sequence(4'hF, 16'hFFFF, 8'd1, 10);

        // all-ones frame fields, one repeat frame
        load_setup(24'hFFFFFF, 8'hFF, 12'd1, 16'd1, 17'd1, 16'd1, 17'd1);
        run_sequence(4'hF, 16'hFFFF, 8'd1, 2);
        run_sequence(4'h0, 16'h0000, 8'd0, 0);

        load_setup(24'h5AC3E1, 8'h3C, 12'd2, 16'd3, 17'd2, 16'd2, 17'd3);
        run_sequence(4'hA, 16'h5AA5, 8'd0, 5);

        // longer segments, sent without stalls
        steady = 1'b1;
        load_setup(24'hA53C96, 8'hA7, 12'd1, 16'd20, 17'd30, 16'd15, 17'd25);
        run_sequence(4'h5, 16'h1234, 8'd0, 0);
        steady = 1'b0;

        rand_base = items_queued;
        while (items_queued - rand_base < RANDOM_ITEMS) begin
            load_setup(24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 255)),
                       12'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 6)
                                                       : $urandom_range(0, 2)),
                       16'($urandom_range(0, 12)), 17'($urandom_range(0, 24)),
                       16'($urandom_range(0, 10)), 17'($urandom_range(0, 24)));
            repeat ($urandom_range(1, 3)) begin
                steady = ($urandom_range(0, 3) == 0);
                run_sequence(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                             8'(($urandom_range(0, 4) == 0) ? $urandom_range(3, 4)
                                                            : $urandom_range(0, 1)), 4);
                repeat ($urandom_range(0, 3)) push_tick();
            end
            steady = 1'b0;
        end

        drain();
        repeat (10) @(negedge aclk);
        if (level_expect_q.size() != 0)
            flag_mismatch("results never delivered", 0, level_expect_q.size());

        $display("checked %0d results over %0d register setups", results_seen, setups_loaded);
        $display("%0d transmissions, %0d completions, %0d starts dropped while busy",
                 tx_started, done_seen, starts_dropped);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rtsfw_pkg.sv
hw/rtl/rtsfw_front.sv
hw/rtl/rtsfw_queue.sv
hw/rtl/rtsfw_back.sv
hw/rtl/rts_frame_waveform_transmitter_core.sv
tb/sv/rts_frame_waveform_transmitter_core_tb.sv
